// ----- design/fixed_block_pool_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Shorthand for the concurrent checks on the allocator ports.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, reset values, codes and shared types of the allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int DEF_MAX_CHUNKS  = 256;

  localparam int CHUNK_COUNT_W   = 9;
  localparam int CHUNK_BYTES_W   = 17;
  localparam int REQ_W           = 17;
  localparam int REL_W           = 8;
  localparam int STATUS_W        = 3;
  localparam int GIDX_W          = 8;
  localparam int GOFF_W          = 24;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 17;

  localparam logic [CHUNK_COUNT_W-1:0] CHUNK_COUNT_RST = 9'd256;
  localparam logic [CHUNK_BYTES_W-1:0] CHUNK_BYTES_RST = 17'd64;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_OOM       = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_DOUBLE    = 3'd4
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHUNK_COUNT = 2'd0,
    REG_CHUNK_BYTES = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  // Configuration as seen by the control path.
  typedef struct packed {
    logic                     rebuild;
    logic [CHUNK_BYTES_W-1:0] chunk_bytes;
  } cfg_t;

endpackage

// ----- design/fbpa_link_ram.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator link memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_link_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/fbpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator control
// Free list head, rebuild sweep, read-modify-write of the link memory and
// the result register.
// ----------------------------------------------------------------------------
module fbpa_ctrl import fbpa_pkg::*; #(
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS,
  parameter int CNT_W      = $clog2(MAX_CHUNKS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic [CNT_W-1:0]    live_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [REQ_W-1:0]    request_bytes,
  input  logic [REL_W-1:0]    release_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [GIDX_W-1:0]   granted_index,
  output logic [GOFF_W-1:0]   granted_offset
);

  localparam int IDX_W  = $clog2(MAX_CHUNKS);
  localparam int ENT_W  = IDX_W + 1;
  localparam int CMP_W  = (CNT_W > REL_W) ? CNT_W : REL_W;
  localparam int PROD_W = IDX_W + CHUNK_BYTES_W;

  ctrl_state_t state, state_next;

  logic [IDX_W-1:0]  sweep_idx, sweep_idx_next;
  logic [IDX_W-1:0]  head, head_next;
  logic              head_valid, head_valid_next;

  logic              item_op;
  logic [REQ_W-1:0]  item_req;
  logic [REL_W-1:0]  item_rel;

  status_t           stat, stat_next;
  logic [GIDX_W-1:0] gidx, gidx_next;
  logic [GOFF_W-1:0] goff, goff_next;
  logic              out_valid_next;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENT_W-1:0]  rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;

  logic              accept;
  logic              load;
  logic              sweep_link_valid;
  logic [PROD_W-1:0] product;

  fbpa_link_ram #(
    .DEPTH (MAX_CHUNKS),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_link_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Entry i links to i+1 up to the last live chunk, which ends the list, as do all entries past it.
  assign sweep_link_valid = CNT_W'(sweep_idx) < (live_count - CNT_W'(1));
  assign product          = PROD_W'(head) * PROD_W'(cfg.chunk_bytes);

  assign accept = in_valid && in_ready;
  assign load   = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next      = state;
    sweep_idx_next  = sweep_idx;
    head_next       = head;
    head_valid_next = head_valid;
    stat_next       = stat;
    gidx_next       = gidx;
    goff_next       = goff;
    out_valid_next  = out_valid && !out_ready;
    cfg_ready       = (state != S_EXEC);
    in_ready        = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = head;
    wr_en           = 1'b0;
    wr_addr         = sweep_idx;
    wr_data         = {sweep_link_valid, sweep_idx + IDX_W'(1)};

    unique case (state)
      S_SWEEP: begin
        wr_en          = 1'b1;
        sweep_idx_next = sweep_idx + IDX_W'(1);
        if (sweep_idx == IDX_W'(MAX_CHUNKS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !cfg_valid;
        if (accept) begin
          rd_en      = 1'b1;
          rd_addr    = (operation == OP_FREE) ? IDX_W'(release_index) : head;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (load) begin
          state_next     = S_IDLE;
          out_valid_next = 1'b1;
          stat_next      = STAT_OK;
          gidx_next      = '0;
          goff_next      = '0;
          if (item_op == OP_ALLOC) begin
            if (!head_valid) begin
              stat_next = STAT_OOM;
            end else if (item_req > cfg.chunk_bytes) begin
              stat_next = STAT_TOO_LARGE;
            end else begin
              gidx_next       = GIDX_W'(head);
              goff_next       = GOFF_W'(product);
              head_next       = rd_data[IDX_W-1:0];
              head_valid_next = rd_data[IDX_W];
              wr_en           = 1'b1;
              wr_addr         = head;
              wr_data         = '0;
            end
          end else begin
            if (CMP_W'(item_rel) >= CMP_W'(live_count)) begin
              stat_next = STAT_RANGE;
            end else if (rd_data[IDX_W]) begin
              stat_next = STAT_DOUBLE;
            end else begin
              // Push: the released chunk now points at the old head.
              wr_en           = 1'b1;
              wr_addr         = IDX_W'(item_rel);
              wr_data         = {head_valid, head};
              head_next       = IDX_W'(item_rel);
              head_valid_next = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_SWEEP;
      end
    endcase

    if (cfg.rebuild) begin
      state_next      = S_SWEEP;
      sweep_idx_next  = '0;
      head_next       = '0;
      head_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_idx  <= '0;
      head       <= '0;
      head_valid <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_idx  <= sweep_idx_next;
      head       <= head_next;
      head_valid <= head_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op  <= operation;
      item_req <= request_bytes;
      item_rel <= release_index;
    end
    stat <= stat_next;
    gidx <= gidx_next;
    goff <= goff_next;
  end

  assign status         = stat;
  assign granted_index  = gidx;
  assign granted_offset = goff;

endmodule

// ----- design/fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back equal-size chunks of a pool kept as a LIFO
// free list, with the links held in a single-port-read link memory.
//
//   channel   direction  handshake              word
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in        in         in_valid / in_ready    operation, request_bytes,
//                                               release_index
//   out       out        out_valid / out_ready  status, granted_index,
//                                               granted_offset
//
// For each word, the link of the head or of the released chunk is read from
// the link memory in the accept cycle, and the head is updated and the result
// registered in the execute state that follows, before a new word is taken.
// After reset, and after each accepted write to a known register, the list
// is rebuilt by a sweep of all MAX_CHUNKS entries, during which in_ready is low.
// A result that is not taken holds the next word in its execute cycle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  logic [REQ_W-1:0]       request_bytes,
  input  logic [REL_W-1:0]       release_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [GIDX_W-1:0]      granted_index,
  output logic [GOFF_W-1:0]      granted_offset
);

  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int CLMP_W = (CNT_W > CHUNK_COUNT_W) ? CNT_W : CHUNK_COUNT_W;

  logic [CHUNK_COUNT_W-1:0] chunk_count;
  logic [CHUNK_BYTES_W-1:0] chunk_bytes;
  logic [CNT_W-1:0]         live_count;
  logic                     cfg_write;
  logic                     known_reg;
  cfg_t                     cfg;

  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index)
      REG_CHUNK_COUNT,
      REG_CHUNK_BYTES: known_reg = 1'b1;
      default:         known_reg = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= CHUNK_COUNT_RST;
      chunk_bytes <= CHUNK_BYTES_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHUNK_COUNT: chunk_count <= cfg_data[CHUNK_COUNT_W-1:0];
        REG_CHUNK_BYTES: chunk_bytes <= cfg_data[CHUNK_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // The pool in use is the written count held to the range 1..MAX_CHUNKS.
  always_comb begin
    if (chunk_count == '0) begin
      live_count = CNT_W'(1);
    end else if (CLMP_W'(chunk_count) > CLMP_W'(MAX_CHUNKS)) begin
      live_count = CNT_W'(MAX_CHUNKS);
    end else begin
      live_count = CNT_W'(chunk_count);
    end
  end

  assign cfg.rebuild     = cfg_write && known_reg;
  assign cfg.chunk_bytes = chunk_bytes;

  fbpa_ctrl #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .live_count     (live_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .request_bytes  (request_bytes),
    .release_index  (release_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_index  (granted_index),
    .granted_offset (granted_offset)
  );

endmodule

// ----- design/fbpa_checker.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator checker
// Port-level checks on result hold, error results, chunk-zero offsets, word spacing and rebuild start.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_checker import fbpa_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    status,
  input logic [GIDX_W-1:0]      granted_index,
  input logic [GOFF_W-1:0]      granted_offset
);

  logic cfg_known;

  // Only a write to a real register starts a rebuild of the free list.
  assign cfg_known = (cfg_index == REG_CHUNK_COUNT) || (cfg_index == REG_CHUNK_BYTES);

  `FBPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_index) && $stable(granted_offset), "stalled result changed")
  `FBPA_ASSERT_SAME(a_err_zero, out_valid && (status != STAT_OK), (granted_index == '0) && (granted_offset == '0), "error result carries a grant")
  `FBPA_ASSERT_SAME(a_idx0_off0, out_valid && (status == STAT_OK) && (granted_index == '0), granted_offset == '0, "chunk zero with nonzero offset")
  `FBPA_ASSERT_NEXT(a_in_spacing, in_valid && in_ready, !in_ready, "word accepted in back-to-back cycles")
  `FBPA_ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready && cfg_known, !in_ready, "word accepted right after a rebuild start")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

// ----- tb/sv/fixed_block_pool_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives allocate and free words through the allocator under changing pool
// settings, predicts every result from a private copy of the free list and
// compares each returned word with the oldest prediction.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    status_t           st;
    logic [GIDX_W-1:0] idx;
    logic [GOFF_W-1:0] off;
  } grant_t;

  typedef struct {
    int cnt;
    int bytes;
    int items;
    int alloc_pct;
  } phase_t;

  class pool_scoreboard;
    logic [CHUNK_COUNT_W-1:0] count_reg;
    logic [CHUNK_BYTES_W-1:0] bytes_reg;
    logic [GIDX_W-1:0]        head;
    bit                       head_ok;
    logic [GIDX_W-1:0]        link [DEF_MAX_CHUNKS];
    bit                       link_ok [DEF_MAX_CHUNKS];
    grant_t                   due [$];
    logic [GIDX_W-1:0]        on_loan [$];
    int                       mismatches;
    int                       checked;
    int                       tally [5];

    function new();
      count_reg  = CHUNK_COUNT_RST;
      bytes_reg  = CHUNK_BYTES_RST;
      mismatches = 0;
      checked    = 0;
      foreach (tally[i]) tally[i] = 0;
      rebuild();
    endfunction

    function int live_chunks();
      if (count_reg == 0) return 1;
      if (count_reg > DEF_MAX_CHUNKS) return DEF_MAX_CHUNKS;
      return int'(count_reg);
    endfunction

    function void rebuild();
      int n;
      int i;
      n = live_chunks();
      foreach (link[j]) begin
        link[j]    = '0;
        link_ok[j] = 1'b0;
      end
      for (i = 0; i + 1 < n; i++) begin
        link[i]    = GIDX_W'(i + 1);
        link_ok[i] = 1'b1;
      end
      head    = '0;
      head_ok = 1'b1;
      on_loan.delete();
    endfunction

    // Every write to a known register starts the free list over.
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CHUNK_COUNT) begin
        count_reg = data[CHUNK_COUNT_W-1:0];
        rebuild();
      end else if (idx == REG_CHUNK_BYTES) begin
        bytes_reg = data[CHUNK_BYTES_W-1:0];
        rebuild();
      end
    endfunction

    function void note_request(op_t op, logic [REQ_W-1:0] req, logic [REL_W-1:0] rel);
      grant_t                           g;
      logic [GIDX_W-1:0]                h;
      logic [GIDX_W+CHUNK_BYTES_W-1:0]  prod;
      int                               hit [$];
      g.st  = STAT_OK;
      g.idx = '0;
      g.off = '0;
      if (op == OP_ALLOC) begin
        if (!head_ok) begin
          g.st = STAT_OOM;
        end else if (req > bytes_reg) begin
          g.st = STAT_TOO_LARGE;
        end else begin
          h       = head;
          prod    = h * bytes_reg;
          g.idx   = h;
          g.off   = prod[GOFF_W-1:0];
          head    = link[h];
          head_ok = link_ok[h];
          link[h]    = '0;
          link_ok[h] = 1'b0;
          on_loan.push_back(h);
        end
      end else begin
        if (rel >= live_chunks()) begin
          g.st = STAT_RANGE;
        end else if (link_ok[rel]) begin
          g.st = STAT_DOUBLE;
        end else begin
          // A chunk with a null link is taken back even if it is the list
          // tail, which can close the list into a loop.
          link[rel]    = head;
          link_ok[rel] = head_ok;
          head         = rel;
          head_ok      = 1'b1;
          hit = on_loan.find_first_index(x) with (x == rel);
          if (hit.size() != 0) on_loan.delete(hit[0]);
        end
      end
      due.push_back(g);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [GIDX_W-1:0] idx,
                                 logic [GOFF_W-1:0] off);
      grant_t g;
      if (due.size() == 0) begin
        flag($sformatf("Unexpected result word: status %0d index %0d offset %0d",
                       st, idx, off));
        return;
      end
      g = due.pop_front();
      checked++;
      if (st !== g.st || idx !== g.idx || off !== g.off)
        flag($sformatf("Word %0d: expected status %0d index %0d offset %0d, got status %0d index %0d offset %0d",
                       checked, g.st, g.idx, g.off, st, idx, off));
      else
        tally[int'(g.st)]++;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   operation = 1'b0;
  logic [REQ_W-1:0]       request_bytes = '0;
  logic [REL_W-1:0]       release_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [GIDX_W-1:0]      granted_index;
  logic [GOFF_W-1:0]      granted_offset;

  pool_scoreboard sb;
  bit             steady = 1'b0;
  int             quiet_cycles = 0;
  int             settings_run = 1;

  phase_t plan [10] = '{
    '{0,      8,      80,  50},
    '{1,      0,      80,  55},
    '{2,      7,      100, 50},
    '{16,     64,     160, 55},
    '{131071, 131071, 320, 90},
    '{300,    65536,  150, 50},
    '{5,      100,    140, 45},
    '{256,    8,      160, 60},
    '{64,     -1,     150, 50},
    '{3,      1,      60,  50}
  };

  fixed_block_pool_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .request_bytes  (request_bytes),
    .release_index  (release_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_index  (granted_index),
    .granted_offset (granted_offset)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; none in steady phases.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(op_t op, logic [REQ_W-1:0] req, logic [REL_W-1:0] rel, int gap);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    operation     <= op;
    request_bytes <= req;
    release_index <= rel;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, req, rel);
  endtask

  task automatic send_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  task automatic random_word(int alloc_pct);
    int               r;
    int               pick;
    op_t              op;
    logic [REQ_W-1:0] req;
    logic [REL_W-1:0] rel;
    r   = $urandom_range(0, 99);
    req = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
    rel = REL_W'($urandom_range(0, 255));
    if (r < alloc_pct) begin
      op   = OP_ALLOC;
      pick = $urandom_range(0, 9);
      if (pick == 1)
        req = sb.bytes_reg;
      else if (pick > 1)
        req = REQ_W'($urandom_range(0, int'(sb.bytes_reg)));
    end else begin
      op = OP_FREE;
      // Mostly return a chunk that is out on loan; the rest probes the
      // range check, double frees and frees of the list tail.
      if (r < 90 && sb.on_loan.size() != 0)
        rel = sb.on_loan[$urandom_range(0, sb.on_loan.size() - 1)];
      else if (r < 95)
        rel = REL_W'($urandom_range(0, sb.live_chunks() - 1));
    end
    send_word(op, req, rel, idle_gap());
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_response(status, granted_index, granted_offset);
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (steady || stall_left == 0) begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_gap();
      end else begin
        out_ready <= 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("fixed_block_pool_allocator_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int                    p;
    int                    k;
    logic [CFG_DATA_W-1:0] bytes_data;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings: edges of the size check, double free, and a free of
    // the list tail that folds the list back on itself.
    send_word(OP_ALLOC, 17'd0,       8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'd64,      8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'd65,      8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'h1FFFF,   8'hFF,  idle_gap());
    send_word(OP_FREE,  17'd0,       8'd0,   idle_gap());
    send_word(OP_FREE,  17'h1FFFF,   8'd0,   idle_gap());
    send_word(OP_FREE,  17'd0,       8'd1,   idle_gap());
    send_word(OP_FREE,  17'd0,       8'd255, idle_gap());
    send_word(OP_FREE,  17'd0,       8'hAA,  idle_gap());
    send_word(OP_ALLOC, 17'd1,       8'h55,  idle_gap());
    drain();

    // Two-chunk pool: exhaustion, out-of-memory ahead of the size check,
    // range errors and a chunk freed twice into a loop on itself.
    send_reg(REG_CHUNK_COUNT, 17'd2);
    send_reg(REG_CHUNK_BYTES, 17'd8);
    settings_run++;
    send_word(OP_ALLOC, 17'd8,       8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'd0,       8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'd0,       8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'h1FFFF,   8'd0,   idle_gap());
    send_word(OP_FREE,  17'd0,       8'd2,   idle_gap());
    send_word(OP_FREE,  17'd0,       8'hFF,  idle_gap());
    send_word(OP_FREE,  17'd0,       8'd1,   idle_gap());
    send_word(OP_FREE,  17'd0,       8'd1,   idle_gap());
    send_word(OP_ALLOC, 17'd3,       8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'd3,       8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'd3,       8'd0,   idle_gap());
    send_word(OP_FREE,  17'd0,       8'd0,   idle_gap());
    send_word(OP_ALLOC, 17'd9,       8'd0,   idle_gap());
    drain();

    for (p = 0; p < 10; p++) begin
      steady = ($urandom_range(0, 3) == 0);
      bytes_data = (plan[p].bytes < 0) ? CFG_DATA_W'($urandom_range(8, 65536))
                                        : CFG_DATA_W'(plan[p].bytes);
      send_reg(REG_CHUNK_COUNT, CFG_DATA_W'(plan[p].cnt));
      send_reg(REG_CHUNK_BYTES, bytes_data);
      settings_run++;
      for (k = 0; k < plan[p].items; k++) begin
        // Halfway through one phase, a write to an unused index must leave
        // the free list as it is.
        if (p == 3 && k == plan[p].items / 2) begin
          drain();
          send_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
        end
        random_word(plan[p].alloc_pct);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Summary: %0d words checked over %0d pool settings; granted %0d, out of memory %0d, too large %0d, out of range %0d, double free %0d",
             sb.checked, settings_run, sb.tally[0], sb.tally[1], sb.tally[2],
             sb.tally[3], sb.tally[4]);
    $display("Mismatches seen: %0d", sb.mismatches);
    if (sb.mismatches == 0)
      $display("fixed_block_pool_allocator_tb passed");
    else
      $display("fixed_block_pool_allocator_tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/fbpa_pkg.sv
design/fbpa_link_ram.sv
design/fbpa_ctrl.sv
design/fixed_block_pool_allocator.sv
design/fbpa_checker.sv
tb/sv/fixed_block_pool_allocator_tb.sv
